>>> sv/cbp_pkg.sv
`default_nettype none

package cbp_pkg;

    localparam int MAX_BINS    = 256;
    localparam int BIN_W       = $clog2(MAX_BINS);
    localparam int LVL_W       = 9;
    localparam int COUNT_BITS  = 22;
    localparam int SUM_W       = 30;
    localparam int CMD_W       = 2;
    localparam int PIXEL_W     = 32;
    localparam int CH_W        = 8;
    localparam int COLOR_W     = 24;

    localparam logic [COLOR_W-1:0]    COLOR_SPACE = 24'hFF_FFFF;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [LVL_W-1:0]      LEVELS_RST  = 9'd16;

    // shared divider: widest dividend is a color sum, widest divisor a 24-bit color step
    localparam int DVD_W     = SUM_W;
    localparam int DVS_W     = COLOR_W;
    localparam int DIV_STEPS = DVD_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_ACC   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MEM_RD,
        ST_MEM_DATA,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        PH_LEVEL,
        PH_BIN,
        PH_RED,
        PH_GREEN,
        PH_BLUE
    } phase_t;

    typedef struct packed {
        logic [SUM_W-1:0]      red;
        logic [SUM_W-1:0]      green;
        logic [SUM_W-1:0]      blue;
        logic [COUNT_BITS-1:0] count;
    } bin_entry_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } div_rsp_t;

endpackage

`default_nettype wire

>>> sv/color_bin_palette_averager.sv
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------------
// s_ (in)  | s_valid / s_ready  | s_cmd, s_pixel, s_bin
// m_ (out) | m_valid / m_ready  | m_bin_index, m_avg_red/green/blue, m_pixel_count
// cfg      | cfg_wr_en          | cfg_wr_data (levels)
//
// accumulate runs two 30-step passes of the shared divider
// (color step, then bin) plus a read-modify-write of the bin memory.
// read is a memory read plus, for a non-empty bin, three averaging divider passes.
// clear and no-op go straight to output; clear drops all bin valid bits at once.
// s_ready is high only while the sequencer is idle; a held result sits in the
// output register, so one more beat can be taken while m_ready is low.
// reset is synchronous active low and empties every bin at once.
`default_nettype none

module color_bin_palette_averager (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [cbp_pkg::LVL_W-1:0]          cfg_wr_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [cbp_pkg::CMD_W-1:0]          s_cmd,
    input  wire logic [cbp_pkg::PIXEL_W-1:0]        s_pixel,
    input  wire logic [cbp_pkg::BIN_W-1:0]          s_bin,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [cbp_pkg::BIN_W-1:0]               m_bin_index,
    output logic [cbp_pkg::CH_W-1:0]                m_avg_red,
    output logic [cbp_pkg::CH_W-1:0]                m_avg_green,
    output logic [cbp_pkg::CH_W-1:0]                m_avg_blue,
    output logic [cbp_pkg::COUNT_BITS-1:0]          m_pixel_count
);
    import cbp_pkg::*;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic [CH_W-1:0]  v);
        logic [SUM_W:0] t;
        t = {1'b0, s} + {{(SUM_W + 1 - CH_W){1'b0}}, v};
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [LVL_W-1:0]      levels_reg;
    logic [COLOR_W-1:0]    color_reg, color_next;
    logic [BIN_W-1:0]      addr_reg, addr_next;
    logic [DVS_W-1:0]      step_reg, step_next;
    bin_entry_t            entry_reg, entry_next;

    logic [BIN_W-1:0]      res_idx_reg, res_idx_next;
    logic [CH_W-1:0]       res_r_reg, res_r_next;
    logic [CH_W-1:0]       res_g_reg, res_g_next;
    logic [CH_W-1:0]       res_b_reg, res_b_next;
    logic [COUNT_BITS-1:0] res_cnt_reg, res_cnt_next;

    logic                  m_valid_reg, m_valid_next;
    logic [BIN_W-1:0]      m_idx_reg, m_idx_next;
    logic [CH_W-1:0]       m_r_reg, m_r_next;
    logic [CH_W-1:0]       m_g_reg, m_g_next;
    logic [CH_W-1:0]       m_b_reg, m_b_next;
    logic [COUNT_BITS-1:0] m_cnt_reg, m_cnt_next;

    bin_entry_t            mem [MAX_BINS];
    logic [MAX_BINS-1:0]   bin_vld_reg;
    bin_entry_t            rd_entry_reg;
    logic                  rd_vld_reg;
    bin_entry_t            cur_entry;
    bin_entry_t            wr_entry;
    logic                  wr_en;
    logic                  clr_all;

    logic [LVL_W-1:0]      lvl_used;
    logic [LVL_W-1:0]      lvl_top;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    cbp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

    // levels of zero behave as one, above the bin count as the bin count
    always_comb begin
        if (levels_reg == '0) begin
            lvl_used = LVL_W'(1);
        end else if (levels_reg > LVL_W'(MAX_BINS)) begin
            lvl_used = LVL_W'(MAX_BINS);
        end else begin
            lvl_used = levels_reg;
        end
        lvl_top = lvl_used - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= LEVELS_RST;
        end else if (cfg_wr_en) begin
            levels_reg <= cfg_wr_data;
        end
    end

    // bin memory, read address held by the sequencer
    always_ff @(posedge aclk) begin
        rd_entry_reg <= mem[addr_reg];
        if (wr_en) begin
            mem[addr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= bin_vld_reg[addr_reg];
            if (clr_all) begin
                bin_vld_reg <= '0;
            end else if (wr_en) begin
                bin_vld_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // an entry never written since the last clear reads as empty
    assign cur_entry = rd_vld_reg ? rd_entry_reg : '0;

    always_comb begin
        wr_entry = cur_entry;
        if (cur_entry.count != COUNT_MAX) begin
            wr_entry.red   = sat_add(cur_entry.red,   color_reg[23:16]);
            wr_entry.green = sat_add(cur_entry.green, color_reg[15:8]);
            wr_entry.blue  = sat_add(cur_entry.blue,  color_reg[7:0]);
            wr_entry.count = cur_entry.count + 1'b1;
        end
    end

    // divider operands by phase
    always_comb begin
        div_req.start = (state_reg == ST_DIV_GO);
        case (phase_reg)
            PH_LEVEL: begin
                div_req.dividend = {{(DVD_W - COLOR_W){1'b0}}, COLOR_SPACE};
                div_req.divisor  = {{(DVS_W - LVL_W){1'b0}}, lvl_used};
            end
            PH_BIN: begin
                div_req.dividend = {{(DVD_W - COLOR_W){1'b0}}, color_reg};
                div_req.divisor  = step_reg;
            end
            PH_RED: begin
                div_req.dividend = entry_reg.red;
                div_req.divisor  = {{(DVS_W - COUNT_BITS){1'b0}}, entry_reg.count};
            end
            PH_GREEN: begin
                div_req.dividend = entry_reg.green;
                div_req.divisor  = {{(DVS_W - COUNT_BITS){1'b0}}, entry_reg.count};
            end
            PH_BLUE: begin
                div_req.dividend = entry_reg.blue;
                div_req.divisor  = {{(DVS_W - COUNT_BITS){1'b0}}, entry_reg.count};
            end
            default: begin
                div_req.dividend = {{(DVD_W - COLOR_W){1'b0}}, COLOR_SPACE};
                div_req.divisor  = {{(DVS_W - LVL_W){1'b0}}, lvl_used};
            end
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        color_next   = color_reg;
        addr_next    = addr_reg;
        step_next    = step_reg;
        entry_next   = entry_reg;
        res_idx_next = res_idx_reg;
        res_r_next   = res_r_reg;
        res_g_next   = res_g_reg;
        res_b_next   = res_b_reg;
        res_cnt_next = res_cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_idx_next   = m_idx_reg;
        m_r_next     = m_r_reg;
        m_g_next     = m_g_reg;
        m_b_next     = m_b_reg;
        m_cnt_next   = m_cnt_reg;
        wr_en        = 1'b0;
        clr_all      = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next     = cmd_t'(s_cmd);
                    color_next   = s_pixel[31:8];
                    res_idx_next = '0;
                    res_r_next   = '0;
                    res_g_next   = '0;
                    res_b_next   = '0;
                    res_cnt_next = '0;
                    case (cmd_t'(s_cmd))
                        CMD_ACC: begin
                            phase_next = PH_LEVEL;
                            state_next = ST_DIV_GO;
                        end
                        CMD_READ: begin
                            addr_next    = s_bin;
                            res_idx_next = s_bin;
                            state_next   = ST_MEM_RD;
                        end
                        CMD_CLEAR: begin
                            clr_all    = 1'b1;
                            state_next = ST_OUT;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    case (phase_reg)
                        PH_LEVEL: begin
                            step_next  = div_rsp.quotient[DVS_W-1:0];
                            phase_next = PH_BIN;
                            state_next = ST_DIV_GO;
                        end
                        PH_BIN: begin
                            // top colors divide to levels or above, fold into last bin
                            if (div_rsp.quotient >= {{(DVD_W - LVL_W){1'b0}}, lvl_used}) begin
                                addr_next = lvl_top[BIN_W-1:0];
                            end else begin
                                addr_next = div_rsp.quotient[BIN_W-1:0];
                            end
                            res_idx_next = addr_next;
                            state_next   = ST_MEM_RD;
                        end
                        PH_RED: begin
                            res_r_next = div_rsp.quotient[CH_W-1:0];
                            phase_next = PH_GREEN;
                            state_next = ST_DIV_GO;
                        end
                        PH_GREEN: begin
                            res_g_next = div_rsp.quotient[CH_W-1:0];
                            phase_next = PH_BLUE;
                            state_next = ST_DIV_GO;
                        end
                        default: begin
                            res_b_next = div_rsp.quotient[CH_W-1:0];
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MEM_RD: begin
                state_next = ST_MEM_DATA;
            end
            ST_MEM_DATA: begin
                if (cmd_reg == CMD_ACC) begin
                    wr_en        = 1'b1;
                    res_cnt_next = wr_entry.count;
                    state_next   = ST_OUT;
                end else begin
                    entry_next   = cur_entry;
                    res_cnt_next = cur_entry.count;
                    if (cur_entry.count == '0) begin
                        state_next = ST_OUT;
                    end else begin
                        phase_next = PH_RED;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = res_idx_reg;
                    m_r_next     = res_r_reg;
                    m_g_next     = res_g_reg;
                    m_b_next     = res_b_reg;
                    m_cnt_next   = res_cnt_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_LEVEL;
            cmd_reg     <= CMD_NOP;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            cmd_reg     <= cmd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        color_reg   <= color_next;
        addr_reg    <= addr_next;
        step_reg    <= step_next;
        entry_reg   <= entry_next;
        res_idx_reg <= res_idx_next;
        res_r_reg   <= res_r_next;
        res_g_reg   <= res_g_next;
        res_b_reg   <= res_b_next;
        res_cnt_reg <= res_cnt_next;
        m_idx_reg   <= m_idx_next;
        m_r_reg     <= m_r_next;
        m_g_reg     <= m_g_next;
        m_b_reg     <= m_b_next;
        m_cnt_reg   <= m_cnt_next;
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_bin_index   = m_idx_reg;
    assign m_avg_red     = m_r_reg;
    assign m_avg_green   = m_g_reg;
    assign m_avg_blue    = m_b_reg;
    assign m_pixel_count = m_cnt_reg;

endmodule

`default_nettype wire

>>> sv/cbp_div.sv
`default_nettype none

module cbp_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cbp_pkg::div_req_t div_req,
    output cbp_pkg::div_rsp_t      div_rsp
);
    import cbp_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W-1:0]  dvs_reg;

    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;
    logic [DVS_W-1:0]  rem_next;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIV_STEPS);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (div_req.start) begin
            quo_reg <= div_req.dividend;
            rem_reg <= '0;
            dvs_reg <= div_req.divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

endmodule

`default_nettype wire

>>> sv/cbp_checker.sv
`default_nettype none

module cbp_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_valid,
    input wire logic                               s_ready,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [cbp_pkg::BIN_W-1:0]          m_bin_index,
    input wire logic [cbp_pkg::CH_W-1:0]           m_avg_red,
    input wire logic [cbp_pkg::CH_W-1:0]           m_avg_green,
    input wire logic [cbp_pkg::CH_W-1:0]           m_avg_blue,
    input wire logic [cbp_pkg::COUNT_BITS-1:0]     m_pixel_count
);
    import cbp_pkg::*;

    // a result beat that is not taken holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_bin_index) && $stable(m_avg_red)
            && $stable(m_avg_green) && $stable(m_avg_blue) && $stable(m_pixel_count))
        else $error("result beat changed while stalled");

    // the sequencer is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // an average only comes from a bin that holds pixels
    a_avg_needs_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_pixel_count == '0)
            |-> (m_avg_red == '0) && (m_avg_green == '0) && (m_avg_blue == '0))
        else $error("nonzero average with empty count");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("control not cleared by reset");

endmodule

bind color_bin_palette_averager cbp_checker u_cbp_checker (.*);

`default_nettype wire
